// ===== rtl/bdlp_pkg.sv =====
// Package for the button debounce and long-press detector.
// Holds field widths, register indexes and reset values; no dependencies.
package bdlp_pkg;

   localparam int TIME_WIDTH          = 32;
   localparam int RAW_WIDTH           = 4;
   localparam int POLL_WIDTH          = 8;
   localparam int DEBOUNCE_WIDTH      = 16;
   localparam int LONG_WIDTH          = 16;
   localparam int INDEX_WIDTH         = 2;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int REQ_DATA_WIDTH      = 40;
   localparam int RSP_DATA_WIDTH      = 8;
   localparam int DEFAULT_NUM_BUTTONS = 4;

   localparam logic [POLL_WIDTH-1:0]     POLL_INTERVAL_RESET = 8'd5;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET      = 16'd50;
   localparam logic [LONG_WIDTH-1:0]     LONG_PRESS_RESET    = 16'd1000;
   localparam logic [RAW_WIDTH-1:0]      PRESENT_MASK_RESET  = 4'hF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POLL_INTERVAL = 2'd0,
      CSR_DEBOUNCE      = 2'd1,
      CSR_LONG_PRESS    = 2'd2,
      CSR_PRESENT_MASK  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                   is_long;
      logic [INDEX_WIDTH-1:0] button_index;
      logic                   event_valid;
   } result_type;

endpackage

// ===== rtl/button_debounce_long_press.sv =====
// Button debounce with long-press detection, top level.
// A poll is registered in the input stage, its result then in the result stage.
// Throughput: one poll per cycle while rsp is not stalled; each poll reads the
// button state that the previous poll wrote, so the update is in place for the next.
// Reset is synchronous and active high: it restores the register defaults and
// clears all button state and both pipeline valid flags.
module button_debounce_long_press #(
   parameter int NUM_BUTTONS = bdlp_pkg::DEFAULT_NUM_BUTTONS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: time_ms[31:0], raw_levels[35:32], zero fill.
   input  logic [bdlp_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: event_valid[0], button_index[2:1], is_long[3], zero fill.
   output logic [bdlp_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                 csr_we,
   input  logic [bdlp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdlp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bdlp_pkg::*;

   // Configuration registers.
   logic [POLL_WIDTH-1:0]     poll_interval_ff, poll_interval_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic [LONG_WIDTH-1:0]     long_press_ff, long_press_in;
   logic [RAW_WIDTH-1:0]      present_mask_ff, present_mask_in;

   // Button state.
   logic [TIME_WIDTH-1:0]  last_poll_ff, last_poll_in;
   logic [NUM_BUTTONS-1:0] stable_ff, stable_in;
   logic [NUM_BUTTONS-1:0] long_done_ff, long_done_in;
   logic [TIME_WIDTH-1:0]  change_time_ff [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0]  change_time_in [NUM_BUTTONS];

   // Input stage.
   logic                  s1_valid_ff, s1_valid_in;
   logic [TIME_WIDTH-1:0] s1_time_ff, s1_time_in;
   logic [RAW_WIDTH-1:0]  s1_levels_ff, s1_levels_in;

   // Result stage.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   logic                   res_ready;
   logic                   s1_fire;
   logic                   poll_skip;
   logic [TIME_WIDTH-1:0]  poll_gap;
   logic [NUM_BUTTONS-1:0] pressed;
   logic                   scan_done;
   logic [TIME_WIDTH-1:0]  held;
   logic                   change_ok;
   result_type             result;

   assign res_ready  = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && res_ready;
   assign req_tready = !s1_valid_ff || res_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - $bits(result_type)){1'b0}}, rsp_data_ff};

   assign poll_gap  = s1_time_ff - last_poll_ff;
   assign poll_skip = poll_gap < {{(TIME_WIDTH - POLL_WIDTH){1'b0}}, poll_interval_ff};

   // Buttons without a level bit, and absent buttons, always read released.
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_level
      if (g < RAW_WIDTH) begin : g_wired
         assign pressed[g] = present_mask_ff[g] && !s1_levels_ff[g];
      end else begin : g_unwired
         assign pressed[g] = 1'b0;
      end
   end

   always_comb begin
      poll_interval_in = poll_interval_ff;
      debounce_in      = debounce_ff;
      long_press_in    = long_press_ff;
      present_mask_in  = present_mask_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POLL_INTERVAL: poll_interval_in = csr_wdata[POLL_WIDTH-1:0];
            CSR_DEBOUNCE:      debounce_in      = csr_wdata[DEBOUNCE_WIDTH-1:0];
            CSR_LONG_PRESS:    long_press_in    = csr_wdata[LONG_WIDTH-1:0];
            CSR_PRESENT_MASK:  present_mask_in  = csr_wdata[RAW_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Scan in index order; the first event stops updates of later buttons.
   always_comb begin
      last_poll_in   = last_poll_ff;
      stable_in      = stable_ff;
      long_done_in   = long_done_ff;
      change_time_in = change_time_ff;
      result         = '0;
      scan_done      = 1'b0;
      held           = '0;
      change_ok      = 1'b0;
      if (s1_fire && !poll_skip) begin
         last_poll_in = s1_time_ff;
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            held      = s1_time_ff - change_time_ff[k];
            change_ok = held >= {{(TIME_WIDTH - DEBOUNCE_WIDTH){1'b0}}, debounce_ff};
            if (!scan_done) begin
               if (pressed[k] != stable_ff[k]) begin
                  if (change_ok) begin
                     change_time_in[k] = s1_time_ff;
                     stable_in[k]      = pressed[k];
                     if (!pressed[k]) begin
                        if (!long_done_ff[k]) begin
                           result.event_valid  = 1'b1;
                           result.button_index = INDEX_WIDTH'(k);
                           result.is_long      = 1'b0;
                           scan_done           = 1'b1;
                        end else begin
                           long_done_in[k] = 1'b0;
                        end
                     end
                  end
               end else if (pressed[k] && !long_done_ff[k] &&
                            held >= {{(TIME_WIDTH - LONG_WIDTH){1'b0}}, long_press_ff}) begin
                  long_done_in[k]     = 1'b1;
                  result.event_valid  = 1'b1;
                  result.button_index = INDEX_WIDTH'(k);
                  result.is_long      = 1'b1;
                  scan_done           = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_time_in   = s1_time_ff;
      s1_levels_in = s1_levels_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in  = 1'b1;
         s1_time_in   = req_tdata[TIME_WIDTH-1:0];
         s1_levels_in = req_tdata[TIME_WIDTH +: RAW_WIDTH];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= POLL_INTERVAL_RESET;
         debounce_ff      <= DEBOUNCE_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         present_mask_ff  <= PRESENT_MASK_RESET;
         last_poll_ff     <= '0;
         stable_ff        <= '0;
         long_done_ff     <= '0;
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            change_time_ff[k] <= '0;
         end
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         poll_interval_ff <= poll_interval_in;
         debounce_ff      <= debounce_in;
         long_press_ff    <= long_press_in;
         present_mask_ff  <= present_mask_in;
         last_poll_ff     <= last_poll_in;
         stable_ff        <= stable_in;
         long_done_ff     <= long_done_in;
         change_time_ff   <= change_time_in;
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_time_ff   <= s1_time_in;
      s1_levels_ff <= s1_levels_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // A reset leaves no result pending.
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result pending after reset");

   // While a result is stalled no poll may touch the button state.
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(last_poll_ff) && $stable(long_done_ff)))
      else $error("button state changed during a result stall");

   // A poll that comes too early produces no event.
   a_skip_no_event: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && poll_skip) |=> (rsp_valid_ff && !rsp_data_ff.event_valid))
      else $error("skipped poll produced an event");
`endif

endmodule
